### rtl/qam_hard_decision_slicer_defines.svh
// Assertion macros shared by the slicer RTL.
`ifndef QAM_HARD_DECISION_SLICER_DEFINES_SVH
`define QAM_HARD_DECISION_SLICER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked property, disabled while the active-low reset is asserted.
`define QHDS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked property that is also checked during reset.
`define QHDS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define QHDS_ASSERT(label, clk, rst_n, prop, msg)
`define QHDS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/qhds_pkg.sv
// Shared types, constants and the 16-QAM label table of the slicer.
`timescale 1ns / 1ps
`default_nettype none

package qhds_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned MODE_W           = 2;
  localparam int unsigned AMP_W            = 14;
  localparam int unsigned THR_W            = AMP_W + 1;
  localparam int unsigned SYM_W            = 4;
  localparam int unsigned APB_DW           = 32;
  localparam int unsigned APB_AW           = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_QPSK  = 2'd0,
    MODE_QAM8  = 2'd1,
    MODE_QAM16 = 2'd2
  } mode_e;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_MODE = 1'b0,
    REG_AMP  = 1'b1
  } reg_idx_e;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_QAM16;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 14'd4096;

  // Decision band of one axis against the threshold T.
  typedef enum logic [1:0] {
    BAND_NEG_OUT = 2'd0,  // v < -T
    BAND_NEG_IN  = 2'd1,  // -T <= v < 0
    BAND_POS_IN  = 2'd2,  // 0 <= v < T
    BAND_POS_OUT = 2'd3   // v >= T
  } band_e;

  typedef struct packed {
    band_e band;
    logic  at_neg_thr;  // v == -T exactly
  } axis_class_t;

  function automatic logic [SYM_W-1:0] qam16_symbol(band_e bx, band_e by);
    logic [SYM_W-1:0] sym;
    sym = '0;
    case ({bx, by})
      {BAND_NEG_OUT, BAND_NEG_OUT}: sym = 4'd14;
      {BAND_NEG_OUT, BAND_NEG_IN }: sym = 4'd6;
      {BAND_NEG_OUT, BAND_POS_IN }: sym = 4'd5;
      {BAND_NEG_OUT, BAND_POS_OUT}: sym = 4'd13;
      {BAND_NEG_IN,  BAND_NEG_OUT}: sym = 4'd10;
      {BAND_NEG_IN,  BAND_NEG_IN }: sym = 4'd2;
      {BAND_NEG_IN,  BAND_POS_IN }: sym = 4'd1;
      {BAND_NEG_IN,  BAND_POS_OUT}: sym = 4'd9;
      {BAND_POS_IN,  BAND_NEG_OUT}: sym = 4'd11;
      {BAND_POS_IN,  BAND_NEG_IN }: sym = 4'd3;
      {BAND_POS_IN,  BAND_POS_IN }: sym = 4'd0;
      {BAND_POS_IN,  BAND_POS_OUT}: sym = 4'd8;
      {BAND_POS_OUT, BAND_NEG_OUT}: sym = 4'd15;
      {BAND_POS_OUT, BAND_NEG_IN }: sym = 4'd7;
      {BAND_POS_OUT, BAND_POS_IN }: sym = 4'd4;
      {BAND_POS_OUT, BAND_POS_OUT}: sym = 4'd12;
      default:                      sym = 4'd0;
    endcase
    return sym;
  endfunction

endpackage

`default_nettype wire

### rtl/qam_hard_decision_slicer.sv
// Top level of the QPSK / 8-QAM / 16-QAM hard-decision slicer.
`timescale 1ns / 1ps
`default_nettype none
`include "qam_hard_decision_slicer_defines.svh"

// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    in_phase_i, quadrature_i
// output    out        out_valid_o / out_ready_i  symbol_index_o
// config    in         psel/penable/pwrite        paddr, pwdata, prdata
//
// Every transaction passes through two registers: the sample register and the
// result register. The symbol of a sample is loaded into the result register once
// the decision stage advances, which a stalled result holds back.
// One transaction is accepted per cycle while the pipeline is not stalled; the
// throughput is set by the single decision stage between those two registers.
// Reset clears the valid flags and loads the mode (16-QAM) and unit amplitude
// (4096); the sample and result payload registers are not reset.
// When the result is not taken, the pipeline holds and in_ready_o drops only
// once the sample register is occupied as well.

module qam_hard_decision_slicer #(
  parameter int unsigned SAMPLE_WIDTH = qhds_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phase_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quadrature_i,
  // Symbol channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [qhds_pkg::SYM_W-1:0]    symbol_index_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qhds_pkg::APB_AW-1:0]   paddr,
  input  logic [qhds_pkg::APB_DW-1:0]   pwdata,
  output logic [qhds_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import qhds_pkg::*;

  logic [MODE_W-1:0] cfg_mode;
  logic [THR_W-1:0]  cfg_thresh;

  // Configuration registers. The user must see that they are only written while the slicer is idle,
  // so the decision stage can read them directly; the slicer itself does not enforce this.
  qhds_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .mode_o   (cfg_mode),
    .thresh_o (cfg_thresh)
  );

  // Sample register.
  logic                          s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] x_q, y_q;
  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic [SYM_W-1:0]              sym_q, sym_d;

  logic s1_adv;
  logic in_acc;

  // The decision stage moves forward whenever the result register is empty
  // or its symbol is being taken in this cycle.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_phase_i;
      y_q <= quadrature_i;
    end
    if (s1_adv && s1_valid_q) begin
      sym_q <= sym_d;
    end
  end

  // Band of each axis against the threshold T = 2a.
  axis_class_t cls_x, cls_y;

  qhds_axis_class #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_class_x (
    .sample_i (x_q),
    .thresh_i (cfg_thresh),
    .class_o  (cls_x)
  );

  qhds_axis_class #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_class_y (
    .sample_i (y_q),
    .thresh_i (cfg_thresh),
    .class_o  (cls_y)
  );

  logic x_neg, y_neg;

  // An axis is negative exactly when its band is one of the two lower bands.
  assign x_neg = (cls_x.band == BAND_NEG_OUT) || (cls_x.band == BAND_NEG_IN);
  assign y_neg = (cls_y.band == BAND_NEG_OUT) || (cls_y.band == BAND_NEG_IN);

  // Symbol decision. The reserved mode value falls back to 16-QAM.
  always_comb begin
    sym_d = '0;
    unique case (cfg_mode)
      MODE_QPSK: begin
        // Quadrants counted counterclockwise from the first.
        if (!y_neg) begin
          sym_d = x_neg ? 4'd1 : 4'd0;
        end else begin
          sym_d = x_neg ? 4'd2 : 4'd3;
        end
      end
      MODE_QAM8: begin
        // The quadrature axis is only sliced at zero. Here an in-phase value
        // exactly at minus the threshold belongs to the outer column.
        if (cls_x.band == BAND_POS_IN) begin
          sym_d = y_neg ? 4'd3 : 4'd0;
        end else if (cls_x.band == BAND_NEG_IN && !cls_x.at_neg_thr) begin
          sym_d = y_neg ? 4'd2 : 4'd1;
        end else if (cls_x.band == BAND_POS_OUT) begin
          sym_d = y_neg ? 4'd7 : 4'd4;
        end else begin
          sym_d = y_neg ? 4'd6 : 4'd5;
        end
      end
      default: begin
        // 16-QAM: both axes pick a band, the pair selects the label. A value
        // exactly at minus the threshold falls into the inner band.
        sym_d = qam16_symbol(cls_x.band, cls_y.band);
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_index_o = sym_q;

  // A stalled result with an occupied sample register must block new samples.
  `QHDS_ASSERT(a_stall_blocks_input, clk_i, rst_ni, s1_valid_q && out_valid_o && !out_ready_i |-> !in_ready_o, "sample accepted while pipeline full")
  // An accepted sample always occupies the sample register next cycle.
  `QHDS_ASSERT(a_accept_fills_s1, clk_i, rst_ni, in_valid_i && in_ready_o |=> s1_valid_q, "accepted sample lost")
  // A sample leaving the decision stage always produces a result.
  `QHDS_ASSERT(a_s1_to_out, clk_i, rst_ni, s1_valid_q && s1_adv |=> out_valid_o, "decision stage dropped a sample")
  // QPSK decisions never exceed index three.
  `QHDS_ASSERT(a_qpsk_range, clk_i, rst_ni, s1_valid_q && s1_adv && cfg_mode == MODE_QPSK |=> symbol_index_o[3:2] == 2'b00, "QPSK symbol out of range")
  // 8-QAM decisions never exceed index seven.
  `QHDS_ASSERT(a_qam8_range, clk_i, rst_ni, s1_valid_q && s1_adv && cfg_mode == MODE_QAM8 |=> !symbol_index_o[3], "8-QAM symbol out of range")

endmodule

`default_nettype wire

### rtl/qhds_cfg_regs.sv
// APB-style configuration registers of the slicer.
`timescale 1ns / 1ps
`default_nettype none

module qhds_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qhds_pkg::APB_AW-1:0]   paddr,
  input  logic [qhds_pkg::APB_DW-1:0]   pwdata,
  output logic [qhds_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [qhds_pkg::MODE_W-1:0]   mode_o,
  output logic [qhds_pkg::THR_W-1:0]    thresh_o
);
  import qhds_pkg::*;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [AMP_W-1:0]  amp_q, amp_d;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    mode_d = mode_q;
    amp_d  = amp_q;
    if (wr_en) begin
      unique case (idx)
        REG_MODE: mode_d = pwdata[MODE_W-1:0];
        REG_AMP:  amp_d  = pwdata[AMP_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      amp_q  <= AMP_RESET;
    end else begin
      mode_q <= mode_d;
      amp_q  <= amp_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODE: prdata = APB_DW'(mode_q);
      REG_AMP:  prdata = APB_DW'(amp_q);
      default:  prdata = '0;
    endcase
  end

  assign mode_o   = mode_q;
  // The threshold is twice the unit amplitude.
  assign thresh_o = {amp_q, 1'b0};

endmodule

`default_nettype wire

### rtl/qhds_axis_class.sv
// Classifies one sample into its decision band against the threshold.
`timescale 1ns / 1ps
`default_nettype none

module qhds_axis_class #(
  parameter int unsigned SAMPLE_WIDTH = qhds_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [qhds_pkg::THR_W-1:0]     thresh_i,
  output qhds_pkg::axis_class_t          class_o
);
  import qhds_pkg::*;

  // Wide enough for the sample and for minus the threshold.
  localparam int unsigned CW = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 1;

  logic signed [CW-1:0] v;
  logic signed [CW-1:0] thr;
  logic signed [CW-1:0] neg_thr;

  assign v       = CW'(sample_i);
  assign thr     = $signed(CW'(thresh_i));
  assign neg_thr = -thr;

  always_comb begin
    if (v >= 0) begin
      class_o.band = (v < thr) ? BAND_POS_IN : BAND_POS_OUT;
    end else begin
      class_o.band = (v >= neg_thr) ? BAND_NEG_IN : BAND_NEG_OUT;
    end
    class_o.at_neg_thr = (v == neg_thr);
  end

endmodule

`default_nettype wire
